// ===== rtl/d2q_pkg.sv =====
// Shared types and constants for the D2Q9 BGK collision pipeline.
// No dependencies.
`default_nettype none
package d2q_pkg;
  typedef logic signed [31:0] word_t;

  typedef enum logic [0:0] {
    REG_RELAX = 1'b0,
    REG_FORCE = 1'b1
  } reg_idx_e;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  function automatic word_t sat32(input logic signed [63:0] x);
    if (x > S32_MAX) begin
      return word_t'(S32_MAX);
    end else if (x < S32_MIN) begin
      return word_t'(S32_MIN);
    end
    return x[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/d2q_div.sv =====
// Pipelined signed divider, one quotient bit per stage, one op per cycle while en_i is high.
// Returns sat32(trunc(num*2^FB/den)) with the magnitude clamped before the sign; zero den gives 0.
// Depends on d2q_pkg.
`default_nettype none
module d2q_div #(
  parameter int FB = 24,
  parameter int NW = 36,
  parameter int TW = 8
) (
  input  wire  logic                 clk_i,
  input  wire  logic                 en_i,
  input  wire  logic signed [NW-1:0] num_i,
  input  wire  logic signed [31:0]   den_i,
  input  wire  logic [TW-1:0]        tag_i,
  output       d2q_pkg::word_t       quo_o,
  output       logic [TW-1:0]        tag_o
);
  import d2q_pkg::*;
  localparam int QW = NW + FB;
  localparam int ST = QW;

  logic [QW-1:0] nm_q [ST+1];
  logic [QW-1:0] qt_q [ST+1];
  logic [33:0]   rm_q [ST+1];
  logic [31:0]   dm_q [ST+1];
  logic          ng_q [ST+1];
  logic          dz_q [ST+1];
  logic [TW-1:0] tg_q [ST+1];

  logic [NW-1:0] na;
  logic [32:0]   da;

  always_comb begin
    na = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    da = den_i[31] ? -{den_i[31], den_i} : {den_i[31], den_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm_q[0] <= {na, {FB{1'b0}}};
      qt_q[0] <= '0;
      rm_q[0] <= '0;
      dm_q[0] <= da[31:0];
      ng_q[0] <= num_i[NW-1] ^ den_i[31];
      dz_q[0] <= den_i == '0;
      tg_q[0] <= tag_i;
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_st
    logic [34:0] tr;
    logic [33:0] sh;
    always_comb begin
      sh = {rm_q[s][32:0], nm_q[s][QW-1]};
      tr = {1'b0, sh} - {3'b0, dm_q[s]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nm_q[s+1] <= nm_q[s] << 1;
        if (!tr[34]) begin
          rm_q[s+1] <= tr[33:0];
          qt_q[s+1] <= {qt_q[s][QW-2:0], 1'b1};
        end else begin
          rm_q[s+1] <= sh;
          qt_q[s+1] <= {qt_q[s][QW-2:0], 1'b0};
        end
        dm_q[s+1] <= dm_q[s];
        ng_q[s+1] <= ng_q[s];
        dz_q[s+1] <= dz_q[s];
        tg_q[s+1] <= tg_q[s];
      end
    end
  end

  // quotient magnitude above 2^31-1 saturates anyway
  logic signed [63:0] mag;
  always_comb begin
    if (qt_q[ST] > QW'(64'h7FFF_FFFF)) begin
      mag = 64'sh8000_0000;
    end else begin
      mag = 64'(qt_q[ST]);
    end
    if (dz_q[ST]) begin
      quo_o = '0;
    end else begin
      quo_o = sat32(ng_q[ST] ? -mag : mag);
    end
  end
  assign tag_o = tg_q[ST];
endmodule
`default_nettype wire

// ===== rtl/d2q_lane.sv =====
// One direction's collision lane: equilibrium, relaxation and forcing.
// Five register stages. Depends on d2q_pkg.
`default_nettype none
module d2q_lane #(
  parameter int FB = 24,
  parameter int CX = 0,
  parameter int CY = 0,
  parameter longint W = 0
) (
  input  wire  logic           clk_i,
  input  wire  logic           en_i,
  input  wire  d2q_pkg::word_t f_i,
  input  wire  d2q_pkg::word_t rho_i,
  input  wire  d2q_pkg::word_t u_i,
  input  wire  d2q_pkg::word_t v_i,
  input  wire  d2q_pkg::word_t usq_i,
  input  wire  d2q_pkg::word_t six_i,
  input  wire  logic [25:0]    omega_i,
  output       d2q_pkg::word_t f_o
);
  import d2q_pkg::*;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FB - 1);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FB;

  function automatic word_t fmul(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [63:0] p;
    p = (a * b + HALF) >>> FB;
    return sat32(p);
  endfunction

  word_t cu_q, wr_q, f1_q, us1_q, cc_q;
  word_t p_q, wr2_q, f2_q;
  word_t fe_q, f3_q;
  word_t nf_q;
  logic signed [63:0] cus;
  always_comb begin
    cus = 64'(CX) * 64'(u_i) + 64'(CY) * 64'(v_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cu_q  <= sat32(cus);
      wr_q  <= fmul(W, 64'(rho_i));
      f1_q  <= f_i;
      us1_q <= usq_i;
      p_q   <= sat32(ONE + 3 * 64'(cu_q)
               + ((9 * 64'(fmul(64'(cu_q), 64'(cu_q))) - 3 * 64'(us1_q)) >>> 1));
      wr2_q <= wr_q;
      f2_q  <= f1_q;
      fe_q  <= fmul(64'(wr2_q), 64'(p_q));
      f3_q  <= f2_q;
      cc_q  <= sat32(64'(f3_q)
               + 64'(fmul(64'(omega_i), 64'(sat32(64'(fe_q) - 64'(f3_q))))));
      nf_q  <= sat32(64'(cc_q) + 64'(CX) * 64'(six_i));
    end
  end
  assign f_o = nf_q;
endmodule
`default_nettype wire

// ===== rtl/d2q9_bgk_collision.sv =====
// D2Q9 BGK collision, top level: moments, velocity divide, nine lanes.
// Uses d2q_pkg, d2q_div, d2q_lane.
// Usage:
//   Input channel in_valid_i/in_stall_o carries the nine distributions of a
//   node; output channel out_valid_o/out_stall_i carries nine collided values,
//   density and velocity. One beat per cycle is accepted when the output is
//   not stalled. The pipeline is a lock-step shift: the whole pipe advances
//   when the output register is empty or taken, so in_stall_o follows
//   out_stall_i while the final stage holds a beat.
//   Depth: FRAC_BITS+45 register stages (69 at FRAC_BITS=24); the
//   bit-per-stage velocity divider sets 61 of them at FRAC_BITS=24.
//   Throughput one node per cycle when the output is not stalled.
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 relax_rate,
//   1 body_force) and cfg_data_i; always ready, write only while idle.
//   Reset clears all valid bits and sets relax_rate to 2^24 (1.0 at FRAC_BITS=24), body_force to 0.
`default_nettype none
module d2q9_bgk_collision #(
  parameter int FRAC_BITS = 24
) (
  input  wire  logic         clk_i,
  input  wire  logic         rst_ni,
  input  wire  logic         in_valid_i,
  output       logic         in_stall_o,
  input  wire  logic signed [31:0] f_rest_i,
  input  wire  logic signed [31:0] f_east_i,
  input  wire  logic signed [31:0] f_north_i,
  input  wire  logic signed [31:0] f_west_i,
  input  wire  logic signed [31:0] f_south_i,
  input  wire  logic signed [31:0] f_northeast_i,
  input  wire  logic signed [31:0] f_northwest_i,
  input  wire  logic signed [31:0] f_southwest_i,
  input  wire  logic signed [31:0] f_southeast_i,
  output       logic         out_valid_o,
  input  wire  logic         out_stall_i,
  output       logic signed [31:0] out_rest_o,
  output       logic signed [31:0] out_east_o,
  output       logic signed [31:0] out_north_o,
  output       logic signed [31:0] out_west_o,
  output       logic signed [31:0] out_south_o,
  output       logic signed [31:0] out_northeast_o,
  output       logic signed [31:0] out_northwest_o,
  output       logic signed [31:0] out_southwest_o,
  output       logic signed [31:0] out_southeast_o,
  output       logic signed [31:0] density_o,
  output       logic signed [31:0] vel_x_o,
  output       logic signed [31:0] vel_y_o,
  input  wire  logic         cfg_valid_i,
  output       logic         cfg_ready_o,
  input  wire  logic [0:0]   cfg_index_i,
  input  wire  logic [31:0]  cfg_data_i
);
  import d2q_pkg::*;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] W_REST = (8 * ONE + 9) / 18;
  localparam logic signed [63:0] W_AXIS = (2 * ONE + 9) / 18;
  localparam logic signed [63:0] W_DIAG = (2 * ONE + 36) / 72;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam int DLAT = 36 + FRAC_BITS + 1;
  localparam int TOT = 1 + DLAT + 2 + 5;
  localparam int DX[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DY[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam longint WT[9] = '{W_REST, W_AXIS, W_AXIS, W_AXIS, W_AXIS,
                               W_DIAG, W_DIAG, W_DIAG, W_DIAG};

  logic [25:0] omega_q;
  word_t       force_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q <= 26'd16777216;
      force_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RELAX: omega_q <= cfg_data_i[25:0];
        REG_FORCE: force_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic [TOT-1:0] vld_q;
  assign en = !(vld_q[TOT-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[TOT-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT-2:0], in_valid_i};
    end
  end

  // stage 0: moments
  word_t fin [9];
  assign fin = '{f_rest_i, f_east_i, f_north_i, f_west_i, f_south_i,
                 f_northeast_i, f_northwest_i, f_southwest_i, f_southeast_i};
  logic signed [35:0] rs, mxs, mys;
  always_comb begin
    rs = '0;
    mxs = '0;
    mys = '0;
    for (int i = 0; i < 9; i++) begin
      rs = rs + 36'(fin[i]);
      mxs = mxs + 36'(DX[i]) * 36'(fin[i]);
      mys = mys + 36'(DY[i]) * 36'(fin[i]);
    end
  end
  word_t rho0_q;
  logic signed [35:0] mx_q, my_q;
  logic [287:0] f0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rho0_q <= sat32(64'(rs));
      mx_q <= mxs;
      my_q <= mys;
      for (int i = 0; i < 9; i++) f0_q[i*32 +: 32] <= fin[i];
    end
  end

  word_t ux, vy;
  logic [287:0] tgx;
  logic [31:0]  tgy;
  d2q_div #(.FB(FRAC_BITS), .NW(36), .TW(288)) u_divx (
    .clk_i, .en_i(en), .num_i(mx_q), .den_i(rho0_q),
    .tag_i(f0_q), .quo_o(ux), .tag_o(tgx));
  d2q_div #(.FB(FRAC_BITS), .NW(36), .TW(32)) u_divy (
    .clk_i, .en_i(en), .num_i(my_q), .den_i(rho0_q),
    .tag_i(rho0_q), .quo_o(vy), .tag_o(tgy));

  // force/6 by reciprocal multiply, truncated toward zero
  logic [31:0] fmag, fsix;
  logic [65:0] fprod;
  always_comb begin
    fmag = force_q[31] ? -force_q : force_q;
    fprod = {34'b0, fmag} * {34'b0, 32'hAAAA_AAAB};
    fsix = fprod[65:34];
  end

  // usq: two stages
  word_t u1_q, v1_q, uu_q, vv_q, rho1_q, u2_q, v2_q, usq_q, rho2_q, six_q;
  logic [287:0] f1_q, f2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      uu_q <= sat32(((64'(ux) * 64'(ux)) + HALF) >>> FRAC_BITS);
      vv_q <= sat32(((64'(vy) * 64'(vy)) + HALF) >>> FRAC_BITS);
      u1_q <= ux;
      v1_q <= vy;
      rho1_q <= tgy;
      f1_q <= tgx;
      usq_q <= sat32(64'(uu_q) + 64'(vv_q));
      u2_q <= u1_q;
      v2_q <= v1_q;
      rho2_q <= rho1_q;
      f2_q <= f1_q;
      six_q <= force_q[31] ? -fsix : fsix;
    end
  end

  word_t res [9];
  for (genvar g = 0; g < 9; g++) begin : g_lane
    d2q_lane #(.FB(FRAC_BITS), .CX(DX[g]), .CY(DY[g]), .W(WT[g])) u_lane (
      .clk_i, .en_i(en), .f_i(f2_q[g*32 +: 32]), .rho_i(rho2_q),
      .u_i(u2_q), .v_i(v2_q), .usq_i(usq_q), .six_i(six_q),
      .omega_i(omega_q), .f_o(res[g]));
  end

  word_t mac_q [5][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      mac_q[0] <= '{rho2_q, u2_q, v2_q};
      for (int k = 1; k < 5; k++) mac_q[k] <= mac_q[k-1];
    end
  end

  assign out_rest_o      = res[0];
  assign out_east_o      = res[1];
  assign out_north_o     = res[2];
  assign out_west_o      = res[3];
  assign out_south_o     = res[4];
  assign out_northeast_o = res[5];
  assign out_northwest_o = res[6];
  assign out_southwest_o = res[7];
  assign out_southeast_o = res[8];
  assign density_o = mac_q[4][0];
  assign vel_x_o   = mac_q[4][1];
  assign vel_y_o   = mac_q[4][2];
endmodule
`default_nettype wire

// ===== rtl/d2q_checker.sv =====
// Port-level checker for d2q9_bgk_collision, bound to the top level.
// No package dependencies.
`default_nettype none
module d2q_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic cfg_ready_o,
  input wire logic [31:0] density_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(density_o))
    else $error("output beat dropped under stall");
  a_nostall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config not ready");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i && out_valid_o)
    else $error("stall without downstream cause");
endmodule

bind d2q9_bgk_collision d2q_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .cfg_ready_o, .density_o);
`default_nettype wire
